### rtl/trial_division_prime_test_defines.svh
// Assertion macros shared by the prime test RTL.
// Each macro needs a clock named clock and a reset named reset in scope.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication.
`define TDPT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdpt: same-cycle check failed");

// Next-cycle implication.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdpt: next-cycle check failed");

`endif

### rtl/tdpt_pkg.sv
package tdpt_pkg;

   // Trial divisor sequence: 3 first, then 5, 7, 11, 13, ... (+2, +4, ...)
   localparam int unsigned SMALLEST_PRIME = 2;
   localparam int unsigned DIVISOR_THREE  = 3;
   localparam int unsigned FIRST_DIVISOR  = 5;
   localparam int unsigned STEP_SHORT     = 2;
   localparam int unsigned STEP_SUM       = 6;
   localparam int unsigned STEP_WIDTH     = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESULT
   } tdpt_state_type;

   // Status of the shared divider back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } tdpt_div_status_type;

endpackage

### rtl/trial_division_prime_test.sv
// Trial-division primality test over the 6k+-1 divisor sequence.
//
// Input channel req_*: one item per number; req_tdata holds number in its low
// NUMBER_WIDTH bits. Result channel rsp_*: one item per input item; bit 0 of
// rsp_tdata is is_prime.
// The block works on one item at a time: req_tready is high only while idle.
// After acceptance it settles 0, 1, 2, 3 and even numbers in its classify state, then
// runs a shared bit-serial restoring divider once per trial divisor (3, then
// 5, 7, 11, 13, ...). Each division gives both the remainder (divisibility)
// and the quotient (the divisor-squared bound). The worst 32-bit prime needs
// about 21846 divisions; the divider's loop resolves one quotient bit per cycle.
// The result is held in an output register with rsp_tvalid high until the
// receiver takes it; a stalled receiver simply holds the block in that state.
// Synchronous reset returns the sequencer to idle and drops any pending item.
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((NUMBER_WIDTH + 7) / 8)*8-1:0] req_tdata,  // [NUMBER_WIDTH-1:0] number
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata   // [0] is_prime
);

   tdpt_state_type          state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] n_ff, n_in;
   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    prime_ff, prime_in;
   logic                    div_start;
   logic [NUMBER_WIDTH-1:0] quotient;
   logic [NUMBER_WIDTH-1:0] remainder;
   tdpt_div_status_type     div_status;

   tdpt_divider #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .quotient (quotient),
      .remainder(remainder),
      .status   (div_status)
   );

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      step_in    = step_ff;
      prime_in   = prime_ff;
      div_start  = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n_in     = req_tdata[NUMBER_WIDTH-1:0];
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            // settle the small cases and even numbers; else try 3 first
            if (n_ff < NUMBER_WIDTH'(SMALLEST_PRIME)) begin
               prime_in = 1'b0;
               state_in = ST_RESULT;
            end else if (n_ff <= NUMBER_WIDTH'(DIVISOR_THREE)) begin
               prime_in = 1'b1;
               state_in = ST_RESULT;
            end else if (!n_ff[0]) begin
               prime_in = 1'b0;
               state_in = ST_RESULT;
            end else begin
               d_in     = NUMBER_WIDTH'(DIVISOR_THREE);
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               if (d_ff == NUMBER_WIDTH'(DIVISOR_THREE)) begin
                  // n is at least 5 here, so 3 dividing it means composite
                  if (remainder == '0) begin
                     prime_in = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     d_in     = NUMBER_WIDTH'(FIRST_DIVISOR);
                     step_in  = STEP_WIDTH'(STEP_SHORT);
                     state_in = ST_DIV_START;
                  end
               end else if (d_ff > quotient) begin
                  // divisor squared past n: no factor left to find
                  prime_in = 1'b1;
                  state_in = ST_RESULT;
               end else if (remainder == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  d_in     = d_ff + NUMBER_WIDTH'(step_ff);
                  step_in  = STEP_WIDTH'(STEP_SUM) - step_ff;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      step_ff  <= step_in;
      prime_ff <= prime_in;
   end

   assign rsp_tdata = {7'b0, prime_ff};

   // Never take a new item while a result is still offered
   `TDPT_ASSERT_NOW(a_no_accept_while_result, rsp_tvalid, !req_tready)
   // Divider completes only while the sequencer waits on it
   `TDPT_ASSERT_NOW(a_done_in_wait, div_status.done, state_ff == ST_DIV_WAIT)
   // Trial divisors are always odd
   `TDPT_ASSERT_NOW(a_divisor_odd, state_ff == ST_DIV_WAIT, d_ff[0])
   // An accepted item goes straight to classification
   `TDPT_ASSERT_NEXT(a_accept_to_classify, req_tvalid && req_tready, state_ff == ST_CLASSIFY)

endmodule

### rtl/tdpt_divider.sv
module tdpt_divider
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder,
   output tdpt_div_status_type     status
);

   localparam int CountWidth = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] dvs_ff;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   diff;
   logic                    last_step;

   // One restoring step per cycle: shift in the next dividend bit, try a subtract
   always_comb begin
      trial     = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      diff      = trial - {1'b0, dvs_ff};
      last_step = (count_ff == CountWidth'(NUMBER_WIDTH - 1));
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[NUMBER_WIDTH]) begin
            rem_in = diff[NUMBER_WIDTH-1:0];
         end else begin
            rem_in = trial[NUMBER_WIDTH-1:0];
         end
         quo_in   = {quo_ff[NUMBER_WIDTH-2:0], ~diff[NUMBER_WIDTH]};
         count_in = count_ff + CountWidth'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
